### rtl/bdcl_pkg.sv
// shared types and constants of the button debounce block
`default_nettype none
package bdcl_pkg;

	localparam int NumButtonsDef = 3;
	localparam logic [15:0] DefDebounce = 16'd30;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_LP_ENABLE = 3'd1,
		REG_LP_TIME1  = 3'd2,
		REG_LP_TIME2  = 3'd3,
		REG_LP_TIME3  = 3'd4,
		REG_EV_LIMIT  = 3'd5
	} reg_idx_t;

	// event kinds
	typedef enum logic [1:0] {
		EV_CLICK    = 2'd0,
		EV_LONG     = 2'd1,
		EV_LONG_REL = 2'd2
	} ev_kind_t;

	typedef struct packed {
		logic [15:0]       debounce_time;
		logic [2:0]        lp_enable;
		logic [2:0][15:0]  lp_time;
		logic [1:0]        event_limit;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        is_seed;
		logic [2:0]  pressed;
		logic [31:0] time_now;
	} item_t;

endpackage
`default_nettype wire

### rtl/bdcl_if.sv
// item channel interfaces of the button debounce block
`default_nettype none
interface bdcl_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [2:0]  raw_levels;
	logic [31:0] time_now;
	modport source(output valid, command, raw_levels, time_now, input ready);
	modport sink(input valid, command, raw_levels, time_now, output ready);
endinterface

interface bdcl_out_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [1:0]  button_index;
	logic [1:0]  event_kind;
	logic [31:0] event_time;
	logic [31:0] serial_number;
	logic        deadline_active;
	logic        deadline_due;
	logic [15:0] time_left;
	logic        final_record;
	modport source(output valid, record_kind, button_index, event_kind, event_time,
		serial_number, deadline_active, deadline_due, time_left, final_record,
		input ready);
	modport sink(input valid, record_kind, button_index, event_kind, event_time,
		serial_number, deadline_active, deadline_due, time_left, final_record,
		output ready);
endinterface
`default_nettype wire

### rtl/button_debounce_click_longpress.sv
// top level: configuration registers, input front end and event back end
//
// Debounces up to three active-low buttons and reports clicks and long presses.
// req carries one item per sample: command (0 sample, 1 seed), raw_levels and
// a millisecond time_now. rsp returns the events of that item (at most
// event_limit of them) followed by one status record with final_record set
// and the nearest deadline.
// Configuration goes through cfg_we / cfg_index / cfg_data; the user writes it
// only while idle, which the block itself does not enforce. The back end starts
// an item, runs the phase machine of each button in turn (ending early at the
// event limit, skipped for a seed or a zero limit, holding while an event waits
// for rsp), scans the deadline of each button (the scan ends early at a due
// wait) and loads the status record once the result register is free; the
// per-button sequencer sets these steps.
// A two-entry queue between front and back keeps req accepting while the
// back end works; when rsp stalls, the back end holds and the queue fills.
// Reset returns every button to idle, the serial to 0, debounce to 30 ms and
// the event limit to 3; no result is pending after reset.
`default_nettype none
module button_debounce_click_longpress #(
	parameter int NUM_BUTTONS = bdcl_pkg::NumButtonsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bdcl_in_if.sink          req,
	bdcl_out_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	bdcl_pkg::cfg_t  cfg_q;
	bdcl_pkg::item_t q_item;
	logic            q_valid;
	logic            q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= bdcl_pkg::DefDebounce;
			cfg_q.lp_enable     <= 3'd0;
			cfg_q.lp_time       <= '0;
			cfg_q.event_limit   <= 2'd3;
		end else if (cfg_we) begin
			case (bdcl_pkg::reg_idx_t'(cfg_index))
				bdcl_pkg::REG_DEBOUNCE:  cfg_q.debounce_time <= cfg_data;
				bdcl_pkg::REG_LP_ENABLE: cfg_q.lp_enable     <= cfg_data[2:0];
				bdcl_pkg::REG_LP_TIME1:  cfg_q.lp_time[0]    <= cfg_data;
				bdcl_pkg::REG_LP_TIME2:  cfg_q.lp_time[1]    <= cfg_data;
				bdcl_pkg::REG_LP_TIME3:  cfg_q.lp_time[2]    <= cfg_data;
				bdcl_pkg::REG_EV_LIMIT:  cfg_q.event_limit   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	bdcl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	bdcl_back #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

### rtl/bdcl_front.sv
// input side: accepts items, classifies them and queues them for the back end
`default_nettype none
module bdcl_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bdcl_in_if.sink            req,
	output bdcl_pkg::item_t    q_item,
	output logic               q_valid,
	input  wire logic          q_pop
);

	bdcl_pkg::item_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	bdcl_pkg::item_t cls;

	// classify: seed flag and active-high press vector
	always_comb begin
		cls.is_seed  = req.command;
		cls.pressed  = ~req.raw_levels;
		cls.time_now = req.time_now;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = ent_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("lost push");
`endif

endmodule
`default_nettype wire

### rtl/bdcl_back.sv
// back end: per-button sequencer, deadline scan and result register
`default_nettype none
module bdcl_back #(
	parameter int NUM_BUTTONS = bdcl_pkg::NumButtonsDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bdcl_pkg::cfg_t  cfg,
	input  wire bdcl_pkg::item_t q_item,
	input  wire logic          q_valid,
	output logic               q_pop,
	bdcl_out_if.source         rsp
);

	localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam logic [IW-1:0] LastBtn = IW'(NUM_BUTTONS - 1);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0, PH_WAIT_PRESS = 3'd1, PH_PRESSED = 3'd2,
		PH_WAIT_RELEASE = 3'd3, PH_SEED = 3'd4
	} phase_t;

	typedef enum logic [1:0] {S_IDLE, S_BTN, S_STAT, S_SOUT} state_t;

	state_t      st_q;
	logic [IW-1:0] b_q;
	logic [1:0]  cnt_q;
	logic        act_q;
	logic        due_q;
	logic [15:0] left_q;
	logic [31:0] serial_q;

	phase_t      ph_q    [NUM_BUTTONS];
	logic        held_q  [NUM_BUTTONS];
	logic        lr_q    [NUM_BUTTONS];
	logic [31:0] edge_q  [NUM_BUTTONS];
	logic [31:0] press_q [NUM_BUTTONS];

	// result register
	logic        ov_q;
	logic        o_kind_q;
	logic [1:0]  o_btn_q;
	logic [1:0]  o_ev_q;
	logic [31:0] o_time_q;
	logic [31:0] o_ser_q;
	logic        o_act_q;
	logic        o_due_q;
	logic [15:0] o_left_q;
	logic        o_fin_q;

	logic        slot_free;
	logic        load_out;
	logic [31:0] now;
	logic [15:0] db;
	logic        pr;
	logic        lp_on;
	phase_t      ph;
	logic        n_held, n_lr, upd_edge, upd_press;
	phase_t      n_ph;
	logic        ev;
	bdcl_pkg::ev_kind_t ev_kind;
	logic [31:0] ev_time;
	logic        pass_edge, pass_press;
	logic        lw, cand, is_due;
	logic [31:0] start, diff;
	logic [15:0] dur, rem;

	assign slot_free = !ov_q || rsp.ready;
	assign now       = q_item.time_now;
	assign db        = (cfg.debounce_time == 16'd0) ? bdcl_pkg::DefDebounce
		: cfg.debounce_time;
	assign ph        = ph_q[b_q];
	assign pr        = q_item.pressed[b_q];
	assign lp_on     = cfg.lp_enable[b_q] && (cfg.lp_time[b_q] != 16'd0);
	assign pass_edge  = (now - edge_q[b_q]) >= {16'd0, db};
	assign pass_press = (now - press_q[b_q]) >= {16'd0, cfg.lp_time[b_q]};

	// next state of the current button for a sample item
	always_comb begin
		n_ph = ph; n_held = held_q[b_q]; n_lr = lr_q[b_q];
		upd_edge = 1'b0; upd_press = 1'b0;
		ev = 1'b0; ev_kind = bdcl_pkg::EV_CLICK; ev_time = now;
		case (ph)
			PH_IDLE: begin
				if (pr) begin
					n_held = 1'b1; upd_edge = 1'b1; n_lr = 1'b0; n_ph = PH_WAIT_PRESS;
				end
			end
			PH_WAIT_PRESS: begin
				if (!pr) begin
					n_held = 1'b0; n_ph = PH_IDLE;
				end else if (pass_edge) begin
					n_held = 1'b1; n_ph = PH_PRESSED; upd_press = 1'b1;
				end
			end
			PH_PRESSED: begin
				if (!pr) begin
					n_held = 1'b0; upd_edge = 1'b1; n_ph = PH_WAIT_RELEASE;
				end else if (lp_on && !lr_q[b_q] && pass_press) begin
					n_lr = 1'b1; ev = 1'b1; ev_kind = bdcl_pkg::EV_LONG;
				end
			end
			PH_WAIT_RELEASE: begin
				if (pr) begin
					n_held = 1'b1; n_ph = PH_PRESSED;
				end else if (pass_edge) begin
					n_held = 1'b0; n_ph = PH_IDLE; ev = 1'b1;
					if (lr_q[b_q]) begin
						n_lr = 1'b0; ev_kind = bdcl_pkg::EV_LONG_REL;
					end else begin
						ev_time = press_q[b_q];
					end
				end
			end
			PH_SEED: begin
				if (pr) begin
					n_held = 1'b1;
				end else if (held_q[b_q]) begin
					n_held = 1'b0; upd_edge = 1'b1;
				end else if (pass_edge) begin
					n_ph = PH_IDLE;
				end
			end
			default: begin
				n_ph = PH_IDLE;
			end
		endcase
	end

	// deadline terms of the current button
	always_comb begin
		lw    = (ph == PH_PRESSED) && !lr_q[b_q] && lp_on;
		cand  = (ph == PH_WAIT_PRESS) || (ph == PH_WAIT_RELEASE)
			|| ((ph == PH_SEED) && !held_q[b_q]) || lw;
		start = lw ? press_q[b_q] : edge_q[b_q];
		dur   = lw ? cfg.lp_time[b_q] : db;
		diff  = now - start;
		is_due = diff >= {16'd0, dur};
		rem   = dur - diff[15:0];
	end

	assign q_pop = (st_q == S_SOUT) && slot_free;

	// result register is loaded this cycle
	assign load_out = ((st_q == S_BTN) && ev && slot_free) || q_pop;

	// sequencer, button state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; b_q <= '0; cnt_q <= 2'd0;
			act_q <= 1'b0; due_q <= 1'b0; left_q <= 16'd0; serial_q <= 32'd0;
			ov_q <= 1'b0; o_kind_q <= 1'b0; o_btn_q <= 2'd0; o_ev_q <= 2'd0;
			o_time_q <= 32'd0; o_ser_q <= 32'd0; o_act_q <= 1'b0; o_due_q <= 1'b0;
			o_left_q <= 16'd0; o_fin_q <= 1'b0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				ph_q[i] <= PH_IDLE; held_q[i] <= 1'b0; lr_q[i] <= 1'b0;
				edge_q[i] <= 32'd0; press_q[i] <= 32'd0;
			end
		end else begin
			if (rsp.ready && !load_out) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					b_q <= '0; cnt_q <= 2'd0;
					act_q <= 1'b0; due_q <= 1'b0; left_q <= 16'd0;
					if (q_valid) begin
						if (q_item.is_seed) begin
							for (int i = 0; i < NUM_BUTTONS; i++) begin
								held_q[i] <= q_item.pressed[i];
								lr_q[i]   <= 1'b0;
								if (q_item.pressed[i]) begin
									ph_q[i] <= PH_SEED; edge_q[i] <= now;
								end else begin
									ph_q[i] <= PH_IDLE;
								end
							end
							st_q <= S_STAT;
						end else if (cfg.event_limit == 2'd0) begin
							st_q <= S_STAT;
						end else begin
							st_q <= S_BTN;
						end
					end
				end
				S_BTN: begin
					if (!ev || slot_free) begin
						ph_q[b_q] <= n_ph; held_q[b_q] <= n_held; lr_q[b_q] <= n_lr;
						if (upd_edge) edge_q[b_q] <= now;
						if (upd_press) press_q[b_q] <= now;
						if (ev) begin
							serial_q <= serial_q + 32'd1;
							cnt_q    <= cnt_q + 2'd1;
							ov_q <= 1'b1; o_kind_q <= 1'b0; o_btn_q <= 2'(b_q);
							o_ev_q <= ev_kind; o_time_q <= ev_time;
							o_ser_q <= serial_q + 32'd1;
							o_act_q <= 1'b0; o_due_q <= 1'b0; o_left_q <= 16'd0;
							o_fin_q <= 1'b0;
						end
						if (b_q == LastBtn || (ev && (cnt_q + 2'd1) == cfg.event_limit)) begin
							b_q <= '0; st_q <= S_STAT;
						end else begin
							b_q <= b_q + IW'(1);
						end
					end
				end
				S_STAT: begin
					if (cand) begin
						act_q <= 1'b1;
						if (is_due) begin
							due_q <= 1'b1; left_q <= 16'd0;
						end else if (left_q == 16'd0 || rem < left_q) begin
							left_q <= rem;
						end
					end
					if (b_q == LastBtn || (cand && is_due)) begin
						st_q <= S_SOUT;
					end else begin
						b_q <= b_q + IW'(1);
					end
				end
				S_SOUT: begin
					if (slot_free) begin
						ov_q <= 1'b1; o_kind_q <= 1'b1; o_btn_q <= 2'd0; o_ev_q <= 2'd0;
						o_time_q <= 32'd0; o_ser_q <= 32'd0; o_act_q <= act_q;
						o_due_q <= due_q; o_left_q <= left_q; o_fin_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.record_kind     = o_kind_q;
	assign rsp.button_index    = o_btn_q;
	assign rsp.event_kind      = o_ev_q;
	assign rsp.event_time      = o_time_q;
	assign rsp.serial_number   = o_ser_q;
	assign rsp.deadline_active = o_act_q;
	assign rsp.deadline_due    = o_due_q;
	assign rsp.time_left       = o_left_q;
	assign rsp.final_record    = o_fin_q;

`ifndef SYNTHESIS
	a_status_out: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> ov_q && o_fin_q) else $error("status record missing");
	a_left_active: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_kind_q && o_left_q != 16'd0 |-> o_act_q && !o_due_q)
		else $error("time left without pending wait");
	a_ev_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_BTN |-> cnt_q < cfg.event_limit) else $error("event limit overrun");
	a_serial_step: assert property (@(posedge clk) disable iff (!arst_n)
		serial_q != $past(serial_q) |-> serial_q == $past(serial_q) + 32'd1)
		else $error("serial skipped");
`endif

endmodule
`default_nettype wire
